/* design/rgr_pkg.sv */
// Package with the shared types, codes and character constants of the grammar recognizer.
`timescale 1ns / 1ps

package rgr_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_CHAR  = 2'd1,
        CMD_END   = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    localparam logic [1:0] FORM_EMPTY  = 2'd0;
    localparam logic [1:0] FORM_LETTER = 2'd1;
    localparam logic [1:0] FORM_PAIR   = 2'd2;

    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic latch;
        logic load;
        logic clear;
        logic scan_start;
        logic scan_next;
        logic finish;
        logic found;
    } t_ctrl;

    typedef struct packed {
        logic scan_en;
        logic hit;
        logic last;
    } t_stat;

endpackage

/* design/regular_grammar_recognizer.sv */
// Top level of the right-linear grammar recognizer: controller and datapath.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-----------------------------------------------
//  command  | i_start, o_busy    | i_command, i_rule_source, i_rule_form,
//           |                    | i_symbol, i_rule_target
//  result   | o_valid (strobe)   | o_accepted, o_last_state
//
// A transaction is taken at a rising edge with i_start high and o_busy low.
// Load and clear leave o_busy low, so they may follow each other in every cycle.
// A word character or end of word holds o_busy high while the rule memory is scanned
// in load order, one entry per cycle through its single read port; the scan stops at
// the first match or the last stored rule, and ends at once when no scan is needed or
// no rule is stored.
// The end-of-word result is strobed on o_valid for one cycle after its scan ends.
// i_rst_n is synchronous; it clears the rule count and word state, not the memory.
// The receiver cannot stall the result.
`timescale 1ns / 1ps

module regular_grammar_recognizer #(
    parameter int MAX_RULES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [1:0] i_command,
    input  logic [7:0] i_rule_source,
    input  logic [1:0] i_rule_form,
    input  logic [7:0] i_symbol,
    input  logic [7:0] i_rule_target,
    output logic       o_valid,
    output logic       o_accepted,
    output logic [7:0] o_last_state
);

    rgr_pkg::t_ctrl w_ctrl;
    rgr_pkg::t_stat w_stat;

    rgr_controller u_controller (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_ctrl    (w_ctrl),
        .o_busy    (o_busy)
    );

    rgr_datapath #(
        .MAX_RULES (MAX_RULES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_command     (i_command),
        .i_rule_source (i_rule_source),
        .i_rule_form   (i_rule_form),
        .i_symbol      (i_symbol),
        .i_rule_target (i_rule_target),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_accepted    (o_accepted),
        .o_last_state  (o_last_state)
    );

endmodule

/* design/rgr_controller.sv */
// Controller state machine that sequences rule loads, clears and the rule table scans.
`timescale 1ns / 1ps

module rgr_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_command,
    input  rgr_pkg::t_stat i_stat,
    output rgr_pkg::t_ctrl o_ctrl,
    output logic           o_busy
);

    rgr_pkg::t_state r_state;
    rgr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rgr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_busy  = 1'b0;
        case (r_state)
            rgr_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_ctrl.latch = 1'b1;
                    case (i_command)
                        rgr_pkg::CMD_LOAD: begin
                            o_ctrl.load = 1'b1;
                        end
                        rgr_pkg::CMD_CLEAR: begin
                            o_ctrl.clear = 1'b1;
                        end
                        default: begin
                            o_ctrl.scan_start = 1'b1;
                            n_state = rgr_pkg::ST_SCAN;
                        end
                    endcase
                end
            end
            rgr_pkg::ST_SCAN: begin
                o_busy = 1'b1;
                if (!i_stat.scan_en || i_stat.hit || i_stat.last) begin
                    o_ctrl.finish = 1'b1;
                    o_ctrl.found  = i_stat.scan_en && i_stat.hit;
                    n_state = rgr_pkg::ST_IDLE;
                end else begin
                    o_ctrl.scan_next = 1'b1;
                end
            end
            default: begin
                n_state = rgr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/rgr_datapath.sv */
// Datapath with the rule memory, the word walk registers and the result register.
`timescale 1ns / 1ps

module rgr_datapath #(
    parameter int MAX_RULES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rgr_pkg::t_ctrl i_ctrl,
    input  logic [1:0]     i_command,
    input  logic [7:0]     i_rule_source,
    input  logic [1:0]     i_rule_form,
    input  logic [7:0]     i_symbol,
    input  logic [7:0]     i_rule_target,
    output rgr_pkg::t_stat o_stat,
    output logic           o_valid,
    output logic           o_accepted,
    output logic [7:0]     o_last_state
);

    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

    logic [7:0] r_mem_src    [MAX_RULES];
    logic [7:0] r_mem_letter [MAX_RULES];
    logic [7:0] r_mem_dest   [MAX_RULES];

    logic [7:0]       r_rd_src;
    logic [7:0]       r_rd_letter;
    logic [7:0]       r_rd_dest;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_cur;
    logic [7:0]       r_prev;
    logic             r_failed;
    logic             r_saw;
    logic             r_is_end;
    logic [7:0]       r_key_letter;
    logic             r_valid;
    logic             r_accepted;
    logic [7:0]       r_last_state;

    logic             w_full;
    logic             w_write;
    logic [7:0]       w_letter;
    logic [7:0]       w_dest;
    logic             w_acc;

    assign w_full  = (r_count == CNT_W'(MAX_RULES));
    assign w_write = i_ctrl.load && !w_full && (i_rule_form <= rgr_pkg::FORM_PAIR);

    always_comb begin
        w_letter = i_symbol;
        w_dest   = rgr_pkg::CH_E;
        if (i_rule_form == rgr_pkg::FORM_EMPTY) begin
            w_letter = rgr_pkg::CH_ZERO;
        end else if (i_rule_form == rgr_pkg::FORM_PAIR) begin
            w_dest = i_rule_target;
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (i_ctrl.scan_start) begin
            n_idx = '0;
        end else if (i_ctrl.scan_next) begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem_src[r_count[IDX_W-1:0]]    <= i_rule_source;
            r_mem_letter[r_count[IDX_W-1:0]] <= w_letter;
            r_mem_dest[r_count[IDX_W-1:0]]   <= w_dest;
        end
        r_rd_src    <= r_mem_src[n_idx];
        r_rd_letter <= r_mem_letter[n_idx];
        r_rd_dest   <= r_mem_dest[n_idx];
    end

    always_comb begin
        if (r_is_end) begin
            o_stat.scan_en = r_saw && !r_failed && (r_cur == rgr_pkg::CH_S)
                             && (r_count != '0);
        end else begin
            o_stat.scan_en = !r_failed && (r_cur != rgr_pkg::CH_E) && (r_count != '0);
        end
        o_stat.hit  = (r_rd_src == r_cur) && (r_rd_letter == r_key_letter);
        o_stat.last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    end

    assign w_acc = r_saw && !r_failed
                   && ((r_cur == rgr_pkg::CH_E) || ((r_cur == rgr_pkg::CH_S) && i_ctrl.found));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch) begin
            r_is_end     <= (i_command == rgr_pkg::CMD_END);
            r_key_letter <= (i_command == rgr_pkg::CMD_END) ? rgr_pkg::CH_ZERO : i_symbol;
        end
        r_idx <= n_idx;
        if (i_ctrl.finish && r_is_end) begin
            r_accepted   <= w_acc;
            r_last_state <= !w_acc ? 8'd0 :
                            (r_cur == rgr_pkg::CH_E) ? r_prev : rgr_pkg::CH_S;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cur    <= rgr_pkg::CH_S;
            r_prev   <= rgr_pkg::CH_S;
            r_failed <= 1'b0;
            r_saw    <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_ctrl.finish && r_is_end;
            if (i_ctrl.clear) begin
                r_count <= '0;
            end else if (w_write) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_ctrl.finish) begin
                if (r_is_end) begin
                    r_cur    <= rgr_pkg::CH_S;
                    r_prev   <= rgr_pkg::CH_S;
                    r_failed <= 1'b0;
                    r_saw    <= 1'b0;
                end else begin
                    r_saw <= 1'b1;
                    if (!r_failed) begin
                        if (i_ctrl.found) begin
                            r_prev <= r_cur;
                            r_cur  <= r_rd_dest;
                        end else begin
                            r_failed <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_accepted   = r_accepted;
    assign o_last_state = r_last_state;

endmodule

/* tb/sv/tb_regular_grammar_recognizer.sv */
// Self-checking testbench for the right-linear grammar recognizer.
`timescale 1ns / 1ps

module tb_regular_grammar_recognizer;

    localparam int TABLE_DEPTH = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [1:0] FORM_BAD = 2'd3;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] LT_A = 8'h61;
    localparam logic [7:0] LT_B = 8'h62;
    localparam logic [7:0] LT_C = 8'h63;
    localparam logic [7:0] LT_Q = 8'h71;
    localparam logic [7:0] LT_X = 8'h78;
    localparam logic [7:0] LT_Z = 8'h7a;

    typedef struct {
        logic       accepted;
        logic [7:0] last_state;
    } t_verdict;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    logic [1:0] i_command;
    logic [7:0] i_rule_source;
    logic [1:0] i_rule_form;
    logic [7:0] i_symbol;
    logic [7:0] i_rule_target;
    logic       o_valid;
    logic       o_accepted;
    logic [7:0] o_last_state;

    regular_grammar_recognizer #(
        .MAX_RULES(TABLE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_command    (i_command),
        .i_rule_source(i_rule_source),
        .i_rule_form  (i_rule_form),
        .i_symbol     (i_symbol),
        .i_rule_target(i_rule_target),
        .o_valid      (o_valid),
        .o_accepted   (o_accepted),
        .o_last_state (o_last_state)
    );

    logic [7:0]  gram_src [TABLE_DEPTH];
    logic [7:0]  gram_letter [TABLE_DEPTH];
    logic [7:0]  gram_dest [TABLE_DEPTH];
    int unsigned gram_count;
    logic [7:0]  walk_state;
    logic [7:0]  walk_prev;
    bit          walk_dead;
    bit          walk_seen;

    t_verdict verdict_q[$];

    int error_count;
    int items_sent;
    int words_checked;
    int words_accepted;
    int rules_dropped;
    int burst_left;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    function automatic bit find_rule(input logic [7:0] src, input logic [7:0] letter,
                                     output int idx);
        idx = 0;
        for (int k = 0; k < gram_count; k++) begin
            if (gram_src[k] == src && gram_letter[k] == letter) begin
                idx = k;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic predict_item(input rgr_pkg::t_cmd cmd, input logic [7:0] src,
                                input logic [1:0] form, input logic [7:0] sym,
                                input logic [7:0] tgt);
        int       k;
        t_verdict v;
        case (cmd)
            rgr_pkg::CMD_LOAD: begin
                if (form != FORM_BAD && gram_count < TABLE_DEPTH) begin
                    gram_src[gram_count] = src;
                    gram_letter[gram_count] = (form == rgr_pkg::FORM_EMPTY) ?
                                              rgr_pkg::CH_ZERO : sym;
                    gram_dest[gram_count] = (form == rgr_pkg::FORM_PAIR) ?
                                            tgt : rgr_pkg::CH_E;
                    gram_count++;
                end else if (form != FORM_BAD) begin
                    rules_dropped++;
                end
            end
            rgr_pkg::CMD_CHAR: begin
                walk_seen = 1'b1;
                if (!walk_dead) begin
                    if (walk_state == rgr_pkg::CH_E || !find_rule(walk_state, sym, k)) begin
                        walk_dead = 1'b1;
                    end else begin
                        walk_prev = walk_state;
                        walk_state = gram_dest[k];
                    end
                end
            end
            rgr_pkg::CMD_END: begin
                v.accepted = 1'b0;
                v.last_state = 8'h00;
                if (walk_seen && !walk_dead) begin
                    if (walk_state == rgr_pkg::CH_E) begin
                        v.accepted = 1'b1;
                        v.last_state = walk_prev;
                    end else if (walk_state == rgr_pkg::CH_S &&
                                 find_rule(rgr_pkg::CH_S, rgr_pkg::CH_ZERO, k)) begin
                        v.accepted = 1'b1;
                        v.last_state = rgr_pkg::CH_S;
                    end
                end
                verdict_q = {verdict_q, v};
                walk_state = rgr_pkg::CH_S;
                walk_prev = rgr_pkg::CH_S;
                walk_dead = 1'b0;
                walk_seen = 1'b0;
            end
            default: begin
                gram_count = 0;
            end
        endcase
    endtask

    task automatic send_item(input rgr_pkg::t_cmd cmd, input logic [7:0] src,
                             input logic [1:0] form, input logic [7:0] sym,
                             input logic [7:0] tgt);
        if (burst_left == 0) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_command = cmd;
        i_rule_source = src;
        i_rule_form = form;
        i_symbol = sym;
        i_rule_target = tgt;
        i_start = 1'b1;
        do @(posedge i_clk); while (o_busy);
        predict_item(cmd, src, form, sym, tgt);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_rule(input logic [7:0] src, input logic [1:0] form,
                             input logic [7:0] sym, input logic [7:0] tgt);
        send_item(rgr_pkg::CMD_LOAD, src, form, sym, tgt);
    endtask

    task automatic send_char(input logic [7:0] sym);
        send_item(rgr_pkg::CMD_CHAR, 8'($urandom), 2'($urandom), sym, 8'($urandom));
    endtask

    task automatic send_end();
        send_item(rgr_pkg::CMD_END, 8'($urandom), 2'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    task automatic send_clear();
        send_item(rgr_pkg::CMD_CLEAR, 8'($urandom), 2'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    task automatic hold_until_drained();
        i_start = 1'b0;
        while (verdict_q.size() != 0) @(negedge i_clk);
        burst_left = 0;
    endtask

    function automatic logic [7:0] pick_state();
        case ($urandom_range(0, 9))
            0: return 8'($urandom);
            1, 2, 3: return rgr_pkg::CH_S;
            4, 5: return CH_A;
            6, 7: return CH_B;
            default: return CH_C;
        endcase
    endfunction

    function automatic logic [7:0] pick_letter_code();
        case ($urandom_range(0, 9))
            0: return 8'($urandom);
            1: return rgr_pkg::CH_ZERO;
            2, 3, 4: return LT_A;
            5, 6: return LT_B;
            default: return LT_C;
        endcase
    endfunction

    function automatic logic [7:0] pick_walk_letter();
        int cand[$];
        for (int k = 0; k < gram_count; k++) begin
            if (gram_src[k] == walk_state) cand = {cand, k};
        end
        if (walk_dead || cand.size() == 0 || $urandom_range(0, 5) == 0) begin
            return pick_letter_code();
        end
        return gram_letter[cand[$urandom_range(0, cand.size() - 1)]];
    endfunction

    task automatic send_random_rule();
        logic [1:0] form;
        logic [7:0] tgt;
        case ($urandom_range(0, 9))
            0: form = rgr_pkg::FORM_EMPTY;
            1: form = FORM_BAD;
            2, 3: form = rgr_pkg::FORM_LETTER;
            default: form = rgr_pkg::FORM_PAIR;
        endcase
        tgt = ($urandom_range(0, 4) == 0) ? rgr_pkg::CH_E : pick_state();
        load_rule(pick_state(), form, pick_letter_code(), tgt);
    endtask

    task automatic test_empty_word();
        send_end();
    endtask

    task automatic test_rule_forms();
        send_clear();
        load_rule(rgr_pkg::CH_S, rgr_pkg::FORM_PAIR, LT_A, CH_A);
        load_rule(CH_A, rgr_pkg::FORM_LETTER, LT_B, 8'($urandom));
        load_rule(rgr_pkg::CH_S, rgr_pkg::FORM_EMPTY, 8'($urandom), 8'($urandom));
        load_rule(rgr_pkg::CH_S, FORM_BAD, LT_C, CH_A);
        load_rule(rgr_pkg::CH_S, rgr_pkg::FORM_PAIR, LT_X, rgr_pkg::CH_S);
        send_char(LT_A);
        send_char(LT_B);
        send_end();
        send_char(LT_X);
        send_end();
        send_char(rgr_pkg::CH_ZERO);
        send_end();
        send_char(LT_C);
        send_end();
        send_char(LT_A);
        send_char(LT_B);
        send_char(LT_X);
        send_end();
    endtask

    task automatic test_order_and_clear();
        load_rule(rgr_pkg::CH_S, rgr_pkg::FORM_PAIR, LT_A, CH_B);
        send_char(LT_Z);
        send_char(LT_A);
        send_char(LT_B);
        send_end();
        send_char(LT_A);
        send_clear();
        load_rule(CH_A, rgr_pkg::FORM_LETTER, LT_B, 8'($urandom));
        send_char(LT_B);
        send_end();
    endtask

    task automatic test_field_extremes();
        send_clear();
        load_rule(rgr_pkg::CH_S, rgr_pkg::FORM_PAIR, 8'hff, 8'h00);
        load_rule(8'h00, rgr_pkg::FORM_PAIR, 8'h00, 8'hff);
        load_rule(8'hff, rgr_pkg::FORM_LETTER, 8'hff, 8'h00);
        send_char(8'hff);
        send_char(8'h00);
        send_char(8'hff);
        send_end();
        send_char(8'h00);
        send_end();
    endtask

    task automatic test_full_table();
        send_clear();
        repeat (TABLE_DEPTH - 1) load_rule(CH_B, rgr_pkg::FORM_PAIR, 8'($urandom), CH_C);
        load_rule(rgr_pkg::CH_S, rgr_pkg::FORM_LETTER, LT_Q, 8'($urandom));
        load_rule(rgr_pkg::CH_S, rgr_pkg::FORM_LETTER, LT_A, 8'($urandom));
        send_char(LT_Q);
        send_end();
        send_char(LT_A);
        send_end();
    endtask

    task automatic test_random_grammars();
        int  goal;
        int  half;
        int  n_rules;
        int  len;
        bit  paused;
        goal = items_sent + RANDOM_ITEMS;
        half = items_sent + RANDOM_ITEMS / 2;
        paused = 1'b0;
        while (items_sent < goal) begin
            if (!paused && items_sent >= half) begin
                hold_until_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 7) != 0) send_clear();
            n_rules = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 70)
                                                   : $urandom_range(1, 8);
            repeat (n_rules) send_random_rule();
            repeat ($urandom_range(2, 5)) begin
                len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                repeat (len) begin
                    if ($urandom_range(0, 19) == 0) begin
                        send_item(rgr_pkg::t_cmd'(2'($urandom)), 8'($urandom),
                                  2'($urandom), 8'($urandom), 8'($urandom));
                    end
                    send_char(pick_walk_letter());
                end
                send_end();
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n && o_valid) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result strobed with no word ended");
            end else begin
                v = verdict_q.pop_front();
                words_checked++;
                if (v.accepted) words_accepted++;
                if (o_accepted !== v.accepted) begin
                    report_mismatch($sformatf("accepted %b, expected %b",
                                              o_accepted, v.accepted));
                end
                if (o_last_state !== v.last_state) begin
                    report_mismatch($sformatf("last_state %h, expected %h",
                                              o_last_state, v.last_state));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transaction.", idle_cycles);
            $display("tb_regular_grammar_recognizer: errors");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        items_sent = 0;
        words_checked = 0;
        words_accepted = 0;
        rules_dropped = 0;
        burst_left = 0;
        idle_cycles = 0;
        gram_count = 0;
        walk_state = rgr_pkg::CH_S;
        walk_prev = rgr_pkg::CH_S;
        walk_dead = 1'b0;
        walk_seen = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_command = rgr_pkg::CMD_LOAD;
        i_rule_source = 8'h00;
        i_rule_form = rgr_pkg::FORM_EMPTY;
        i_symbol = 8'h00;
        i_rule_target = 8'h00;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_word();
        test_rule_forms();
        test_order_and_clear();
        test_field_extremes();
        test_full_table();
        test_random_grammars();

        i_start = 1'b0;
        while (verdict_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (verdict_q.size() != 0) begin
            report_mismatch($sformatf("%0d word results never arrived", verdict_q.size()));
        end
        $display("Covered %0d transactions and %0d finished words, %0d of them accepted.",
                 items_sent, words_checked, words_accepted);
        $display("Rules dropped on a full table: %0d; mismatches: %0d.",
                 rules_dropped, error_count);
        if (error_count == 0) begin
            $display("tb_regular_grammar_recognizer: clean");
        end else begin
            $display("tb_regular_grammar_recognizer: errors");
        end
        $finish;
    end

endmodule
